FILE: sv/scv_pkg.sv
// Shared types, constants and helpers for the 3x3 sub-pixel centre block.
// Used by the lane, merge, top-level and checker files; depends on nothing.
package scv_pkg;

    localparam int PIX_W  = 16;
    localparam int POS_W  = 16;
    localparam int GAIN_W = 16;

    // Q4.12 positions: one pixel is 4096.
    localparam logic signed [POS_W-1:0] POS_ZERO = 16'sd0;
    localparam logic signed [POS_W-1:0] POS_ONE  = 16'sd4096;
    localparam logic signed [POS_W-1:0] POS_TWO  = 16'sd8192;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd21845;

    // Quotient steps of the lane dividers and of the intersection divider.
    localparam int LANE_STEPS  = 30;
    localparam int MERGE_STEPS = 16;

    // Register stages from port to result.
    localparam int LANE_LAT  = LANE_STEPS + 7;
    localparam int MERGE_LAT = MERGE_STEPS + 12;
    localparam int TOTAL_LAT = LANE_LAT + MERGE_LAT;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [32:0] v);
        logic signed [POS_W-1:0] r;
        if (v > 33'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -33'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = 16'(v);
        end
        return r;
    endfunction

endpackage

FILE: sv/subpixel_center_3x3.sv
// Top level of the 3x3 sub-pixel centre block: six estimator lanes and the merge.
// Depends on scv_pkg, scv_lane and scv_merge.
//
// Usage: an item (one 3x3 patch of signed pixels) is taken at a rising edge where
// i_start is high and o_busy is low. o_busy is high only in reset and in the cycle
// after it, so a new item can be given in every cycle.
// Three lanes estimate the column centre of each row and three estimate the row
// centre of each column; the merge stage intersects the two fitted lines.
// Each result appears on o_x_center, o_y_center and o_status for one cycle with
// o_done high once its item has passed the lanes, whose delay is set mostly by
// their 30-step quotient pipelines, and the merge, whose delay is set by its
// 16-step divider and the multiply chain of the row centre.
// Throughput is one item per cycle; results leave in the order items arrived.
// The receiver cannot stall the block, so no result is ever held back.
// The curvature gain is written via i_cfg_valid/o_cfg_ready/i_cfg_data; the user
// must write it only while no item is in flight; the block does not enforce it.
// Reset restores the gain to 21845 and drops all items; no strobe until new items enter.
module subpixel_center_3x3 import scv_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  logic signed [PIX_W-1:0] i_pix_r0_c0,
    input  logic signed [PIX_W-1:0] i_pix_r0_c1,
    input  logic signed [PIX_W-1:0] i_pix_r0_c2,
    input  logic signed [PIX_W-1:0] i_pix_r1_c0,
    input  logic signed [PIX_W-1:0] i_pix_r1_c1,
    input  logic signed [PIX_W-1:0] i_pix_r1_c2,
    input  logic signed [PIX_W-1:0] i_pix_r2_c0,
    input  logic signed [PIX_W-1:0] i_pix_r2_c1,
    input  logic signed [PIX_W-1:0] i_pix_r2_c2,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [GAIN_W-1:0]       i_cfg_data,
    output logic                    o_done,
    output logic signed [POS_W-1:0] o_x_center,
    output logic signed [POS_W-1:0] o_y_center,
    output logic                    o_status
);

    logic [GAIN_W-1:0]      r_gain;
    logic                   r_busy;
    logic [TOTAL_LAT-1:0]   r_vld;
    logic                   n_accept;
    logic signed [PIX_W-1:0] w_pix [0:2][0:2];
    logic signed [POS_W-1:0] w_xm [0:2];
    logic signed [POS_W-1:0] w_ym [0:2];

    assign w_pix[0][0] = i_pix_r0_c0;
    assign w_pix[0][1] = i_pix_r0_c1;
    assign w_pix[0][2] = i_pix_r0_c2;
    assign w_pix[1][0] = i_pix_r1_c0;
    assign w_pix[1][1] = i_pix_r1_c1;
    assign w_pix[1][2] = i_pix_r1_c2;
    assign w_pix[2][0] = i_pix_r2_c0;
    assign w_pix[2][1] = i_pix_r2_c1;
    assign w_pix[2][2] = i_pix_r2_c2;

    assign n_accept = i_start & ~r_busy;

    // The data path carries no valid bits; this shift line marks live items.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
            r_busy <= 1'b1;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[TOTAL_LAT-2:0], n_accept};
            if (i_cfg_valid && !r_busy) begin
                r_gain <= i_cfg_data;
            end
        end
    end

    // Rows give column centres, columns give row centres.
    for (genvar g = 0; g < 3; g++) begin : g_lane
        scv_lane u_row (
            .i_clk  (i_clk),
            .i_gain (r_gain),
            .i_f0   (w_pix[g][0]),
            .i_f1   (w_pix[g][1]),
            .i_f2   (w_pix[g][2]),
            .o_pos  (w_xm[g])
        );
        scv_lane u_col (
            .i_clk  (i_clk),
            .i_gain (r_gain),
            .i_f0   (w_pix[0][g]),
            .i_f1   (w_pix[1][g]),
            .i_f2   (w_pix[2][g]),
            .o_pos  (w_ym[g])
        );
    end

    scv_merge u_merge (
        .i_clk    (i_clk),
        .i_x0     (w_xm[0]),
        .i_x1     (w_xm[1]),
        .i_x2     (w_xm[2]),
        .i_y0     (w_ym[0]),
        .i_y1     (w_ym[1]),
        .i_y2     (w_ym[2]),
        .o_x      (o_x_center),
        .o_y      (o_y_center),
        .o_status (o_status)
    );

    assign o_busy      = r_busy;
    assign o_cfg_ready = ~r_busy;
    assign o_done      = r_vld[TOTAL_LAT-1];

endmodule

FILE: sv/scv_lane.sv
// One lane: three-point parabola peak with gain-scaled correction term.
// Pipelined, one patch per cycle; depends on scv_pkg.
module scv_lane import scv_pkg::*; (
    input  logic                    i_clk,
    input  logic [GAIN_W-1:0]       i_gain,
    input  logic signed [PIX_W-1:0] i_f0,
    input  logic signed [PIX_W-1:0] i_f1,
    input  logic signed [PIX_W-1:0] i_f2,
    output logic signed [POS_W-1:0] o_pos
);

    typedef struct packed {
        logic [54:0] den;
        logic [54:0] rem;
        logic [29:0] nlo;
        logic [29:0] q;
        logic [16:0] d1;
        logic [16:0] rem1;
        logic [29:0] n1;
        logic [29:0] q1;
        logic        ddneg;
        logic        neg;
        logic        ov;
        logic        est;
        logic [15:0] fb;
    } t_div;

    function automatic t_div div_step(input t_div s);
        t_div        r;
        logic [55:0] rb;
        logic [17:0] rb1;
        r   = s;
        rb  = {s.rem, s.nlo[29]};
        rb1 = {s.rem1, s.n1[29]};
        r.nlo = {s.nlo[28:0], 1'b0};
        r.n1  = {s.n1[28:0], 1'b0};
        if (rb >= {1'b0, s.den}) begin
            r.rem = 55'(rb - {1'b0, s.den});
            r.q   = {s.q[28:0], 1'b1};
        end else begin
            r.rem = rb[54:0];
            r.q   = {s.q[28:0], 1'b0};
        end
        if (rb1 >= {1'b0, s.d1}) begin
            r.rem1 = 17'(rb1 - {1'b0, s.d1});
            r.q1   = {s.q1[28:0], 1'b1};
        end else begin
            r.rem1 = rb1[16:0];
            r.q1   = {s.q1[28:0], 1'b0};
        end
        return r;
    endfunction

    // Stage 1
    logic signed [17:0] r1_d;
    logic signed [16:0] r1_dd;
    logic signed [15:0] r1_f1;
    logic signed [15:0] r1_fb;
    logic signed [15:0] n1_fb;
    // Stage 2
    logic signed [33:0] r2_p1;
    logic signed [33:0] r2_dd2;
    logic signed [37:0] r2_e;
    logic signed [17:0] r2_d;
    logic signed [16:0] r2_dd;
    logic signed [15:0] r2_fb;
    logic               r2_est;
    // Stage 3
    logic signed [37:0] n3_a;
    logic [35:0]        r3_absa;
    logic               r3_nega;
    logic               r3_azero;
    logic [34:0]        r3_abse;
    logic               r3_nege;
    logic [15:0]        r3_absdd;
    logic               r3_ddneg;
    logic [16:0]        r3_d;
    logic               r3_est;
    logic signed [15:0] r3_fb;
    // Stage 4
    logic [50:0]        r4_m1;
    logic [52:0]        r4_ad;
    logic               r4_neg;
    logic               r4_est;
    logic [15:0]        r4_absdd;
    logic               r4_ddneg;
    logic [16:0]        r4_d;
    logic signed [15:0] r4_fb;
    // Stage 5
    logic [66:0]        r5_num;
    logic [54:0]        r5_den;
    logic               r5_neg;
    logic               r5_est;
    logic [15:0]        r5_absdd;
    logic               r5_ddneg;
    logic [16:0]        r5_d;
    logic signed [15:0] r5_fb;
    // Divider and result
    t_div               n_dv0;
    t_div               r_dv [0:LANE_STEPS];
    t_div               s_end;
    logic signed [32:0] n_t1;
    logic signed [32:0] n_t2;
    logic signed [32:0] n_sum;
    logic signed [15:0] r_pos;

    // Brightest pixel, used when there is no usable curvature.
    always_comb begin
        if (i_f0 > i_f1 && i_f0 > i_f2) begin
            n1_fb = POS_ZERO;
        end else if (i_f2 > i_f1 && i_f2 > i_f0) begin
            n1_fb = POS_TWO;
        end else begin
            n1_fb = POS_ONE;
        end
    end

    assign n3_a = (38'(r2_p1) <<< 3) + 38'(r2_dd2);

    always_comb begin
        n_dv0       = '0;
        n_dv0.den   = r5_den;
        n_dv0.rem   = 55'(r5_num[66:30]);
        n_dv0.nlo   = r5_num[29:0];
        n_dv0.ov    = {18'd0, r5_num[66:30]} >= r5_den;
        n_dv0.d1    = r5_d;
        n_dv0.n1    = {3'b000, r5_absdd, 11'd0};
        n_dv0.ddneg = r5_ddneg;
        n_dv0.neg   = r5_neg;
        n_dv0.est   = r5_est;
        n_dv0.fb    = r5_fb;
    end

    always_ff @(posedge i_clk) begin
        r1_d  <= (18'(i_f1) <<< 1) - 18'(i_f0) - 18'(i_f2);
        r1_dd <= 17'(i_f2) - 17'(i_f0);
        r1_f1 <= i_f1;
        r1_fb <= n1_fb;

        r2_p1  <= r1_d * r1_f1;
        r2_dd2 <= r1_dd * r1_dd;
        r2_e   <= (19'(r1_d) - 19'(r1_dd)) * (19'(r1_d) + 19'(r1_dd));
        r2_d   <= r1_d;
        r2_dd  <= r1_dd;
        r2_fb  <= r1_fb;
        r2_est <= r1_d > 18'sd0;

        r3_absa  <= n3_a[37] ? 36'(-n3_a) : 36'(n3_a);
        r3_nega  <= n3_a[37];
        r3_azero <= n3_a == 38'sd0;
        r3_abse  <= r2_e[37] ? 35'(-r2_e) : 35'(r2_e);
        r3_nege  <= r2_e[37];
        r3_absdd <= r2_dd[16] ? 16'(-r2_dd) : 16'(r2_dd);
        r3_ddneg <= r2_dd[16];
        r3_d     <= 17'(r2_d);
        r3_est   <= r2_est;
        r3_fb    <= r2_fb;

        r4_m1    <= r3_abse * r3_absdd;
        r4_ad    <= r3_absa * r3_d;
        r4_neg   <= r3_ddneg ^ r3_nege ^ r3_nega;
        r4_est   <= r3_est & ~r3_azero;
        r4_absdd <= r3_absdd;
        r4_ddneg <= r3_ddneg;
        r4_d     <= r3_d;
        r4_fb    <= r3_fb;

        r5_num   <= r4_m1 * i_gain;
        r5_den   <= {r4_ad, 2'b00};
        r5_neg   <= r4_neg;
        r5_est   <= r4_est;
        r5_absdd <= r4_absdd;
        r5_ddneg <= r4_ddneg;
        r5_d     <= r4_d;
        r5_fb    <= r4_fb;

        r_dv[0] <= n_dv0;
        for (int k = 0; k < LANE_STEPS; k++) begin
            r_dv[k+1] <= div_step(r_dv[k]);
        end

        r_pos <= s_end.est ? sat_pos(n_sum) : s_end.fb;
    end

    // A correction term this large saturates the sum whatever its exact size.
    always_comb begin
        s_end = r_dv[LANE_STEPS];
        n_t1  = 33'(s_end.q1);
        if (s_end.ddneg) begin
            n_t1 = -n_t1;
        end
        n_t2 = s_end.ov ? 33'sd1073741824 : 33'(s_end.q);
        if (s_end.neg) begin
            n_t2 = -n_t2;
        end
        n_sum = 33'sd4096 + n_t1 + n_t2;
    end

    assign o_pos = r_pos;

endmodule

FILE: sv/scv_merge.sv
// Merge stage: intersects the row-centre line with the column-centre line.
// Pipelined with a 16-step divider; depends on scv_pkg.
module scv_merge import scv_pkg::*; (
    input  logic                    i_clk,
    input  logic signed [POS_W-1:0] i_x0,
    input  logic signed [POS_W-1:0] i_x1,
    input  logic signed [POS_W-1:0] i_x2,
    input  logic signed [POS_W-1:0] i_y0,
    input  logic signed [POS_W-1:0] i_y1,
    input  logic signed [POS_W-1:0] i_y2,
    output logic signed [POS_W-1:0] o_x,
    output logic signed [POS_W-1:0] o_y,
    output logic                    o_status
);

    typedef struct packed {
        logic [36:0]        den;
        logic [36:0]        rem;
        logic [15:0]        nlo;
        logic [15:0]        q;
        logic               sgn;
        logic               ov;
        logic               sing;
        logic signed [16:0] my;
        logic signed [17:0] by;
    } t_xdiv;

    function automatic t_xdiv div_step(input t_xdiv s);
        t_xdiv       r;
        logic [37:0] rb;
        r     = s;
        rb    = {s.rem, s.nlo[15]};
        r.nlo = {s.nlo[14:0], 1'b0};
        if (rb >= {1'b0, s.den}) begin
            r.rem = 37'(rb - {1'b0, s.den});
            r.q   = {s.q[14:0], 1'b1};
        end else begin
            r.rem = rb[36:0];
            r.q   = {s.q[14:0], 1'b0};
        end
        return r;
    endfunction

    logic signed [16:0] r1_mx, r1_my;
    logic signed [17:0] r1_bx, r1_by;
    logic signed [33:0] n2_mm;
    logic signed [36:0] n2_den;
    logic signed [20:0] n2_in;
    logic signed [36:0] r2_den;
    logic signed [20:0] r2_in;
    logic signed [16:0] r2_mx, r2_my;
    logic signed [17:0] r2_bx, r2_by;
    logic signed [37:0] r3_prod;
    logic signed [36:0] r3_den;
    logic signed [16:0] r3_my;
    logic signed [17:0] r3_bx, r3_by;
    logic signed [38:0] r4_num0;
    logic signed [36:0] r4_den;
    logic signed [16:0] r4_my;
    logic signed [17:0] r4_by;
    logic [38:0]        r5_absn;
    logic [36:0]        r5_absd;
    logic               r5_sgn;
    logic               r5_sing;
    logic signed [16:0] r5_my;
    logic signed [17:0] r5_by;
    t_xdiv              n_dv0;
    t_xdiv              r_dv [0:MERGE_STEPS];
    t_xdiv              s_end;
    logic signed [32:0] n_xv;
    logic signed [15:0] rq_xc;
    logic               rq_sing;
    logic signed [16:0] rq_my;
    logic signed [17:0] rq_by;
    logic signed [16:0] n_xm1;
    logic signed [33:0] n_p;
    logic signed [35:0] ry1_t;
    logic signed [15:0] ry1_xc, ry2_xc, ry3_xc, ry4_xc;
    logic               ry1_sing, ry2_sing, ry3_sing, ry4_sing;
    logic signed [17:0] ry1_by;
    logic signed [36:0] ry2_ny;
    logic [36:0]        ry3_absy;
    logic               ry3_sgn, ry4_sgn;
    logic [55:0]        ry4_m;
    logic [22:0]        n_qy;
    logic signed [32:0] n_yv;
    logic signed [15:0] r_x, r_y;
    logic               r_status;

    assign n2_mm  = r1_mx * r1_my;
    assign n2_den = 37'(n2_mm) * 37'sd3 + 37'sd201326592;
    assign n2_in  = (21'(r1_by) <<< 1) - 21'(r1_my) * 21'sd3 - 21'sd24576;

    always_comb begin
        n_dv0      = '0;
        n_dv0.den  = r5_absd;
        n_dv0.rem  = 37'(r5_absn[38:4]);
        n_dv0.nlo  = {r5_absn[3:0], 12'd0};
        n_dv0.ov   = {2'b00, r5_absn[38:4]} >= r5_absd;
        n_dv0.sgn  = r5_sgn;
        n_dv0.sing = r5_sing;
        n_dv0.my   = r5_my;
        n_dv0.by   = r5_by;
    end

    always_comb begin
        s_end = r_dv[MERGE_STEPS];
        if (s_end.ov) begin
            n_xv = s_end.sgn ? -33'sd1048576 : 33'sd1048576;
        end else begin
            n_xv = 33'(s_end.q);
            if (s_end.sgn) begin
                n_xv = -n_xv;
            end
        end
    end

    assign n_xm1 = 17'(rq_xc) - 17'sd4096;
    assign n_p   = n_xm1 * rq_my;
    assign n_qy  = ry4_m[55:33];

    always_comb begin
        n_yv = 33'(n_qy);
        if (ry4_sgn) begin
            n_yv = -n_yv;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_mx <= 17'(i_x2) - 17'(i_x0);
        r1_my <= 17'(i_y2) - 17'(i_y0);
        r1_bx <= 18'(i_x0) + 18'(i_x1) + 18'(i_x2);
        r1_by <= 18'(i_y0) + 18'(i_y1) + 18'(i_y2);

        r2_den <= n2_den;
        r2_in  <= n2_in;
        r2_mx  <= r1_mx;
        r2_my  <= r1_my;
        r2_bx  <= r1_bx;
        r2_by  <= r1_by;

        r3_prod <= r2_mx * r2_in;
        r3_den  <= r2_den;
        r3_my   <= r2_my;
        r3_bx   <= r2_bx;
        r3_by   <= r2_by;

        r4_num0 <= 39'(r3_prod) + (39'(r3_bx) <<< 14);
        r4_den  <= r3_den;
        r4_my   <= r3_my;
        r4_by   <= r3_by;

        r5_absn <= r4_num0[38] ? 39'(-r4_num0) : 39'(r4_num0);
        r5_absd <= r4_den[36] ? 37'(-r4_den) : 37'(r4_den);
        r5_sgn  <= r4_num0[38] ^ r4_den[36];
        r5_sing <= r4_den == 37'sd0;
        r5_my   <= r4_my;
        r5_by   <= r4_by;

        r_dv[0] <= n_dv0;
        for (int k = 0; k < MERGE_STEPS; k++) begin
            r_dv[k+1] <= div_step(r_dv[k]);
        end

        rq_xc   <= sat_pos(n_xv);
        rq_sing <= s_end.sing;
        rq_my   <= s_end.my;
        rq_by   <= s_end.by;

        ry1_t    <= 36'(n_p) * 36'sd3;
        ry1_xc   <= rq_xc;
        ry1_sing <= rq_sing;
        ry1_by   <= rq_by;

        ry2_ny   <= 37'(ry1_t) + (37'(ry1_by) <<< 13);
        ry2_xc   <= ry1_xc;
        ry2_sing <= ry1_sing;

        ry3_absy <= ry2_ny[36] ? 37'(-ry2_ny) : 37'(ry2_ny);
        ry3_sgn  <= ry2_ny[36];
        ry3_xc   <= ry2_xc;
        ry3_sing <= ry2_sing;

        // Divide by 8192 with a shift, then by 3 with a reciprocal product.
        ry4_m    <= ry3_absy[36:13] * 32'hAAAAAAAB;
        ry4_sgn  <= ry3_sgn;
        ry4_xc   <= ry3_xc;
        ry4_sing <= ry3_sing;

        r_x      <= ry4_sing ? POS_ONE : ry4_xc;
        r_y      <= ry4_sing ? POS_ONE : sat_pos(n_yv);
        r_status <= ry4_sing;
    end

    assign o_x      = r_x;
    assign o_y      = r_y;
    assign o_status = r_status;

endmodule

FILE: sv/scv_checker.sv
// Port-level checks for subpixel_center_3x3, attached by the bind below.
// Depends on scv_pkg.
module scv_checker import scv_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_start,
    input logic                    o_busy,
    input logic                    o_done,
    input logic signed [POS_W-1:0] o_x_center,
    input logic signed [POS_W-1:0] o_y_center,
    input logic                    o_status
);

    // Reset empties the pipeline.
    a_no_done_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

    // A singular intersection always reports the nominal centre.
    a_singular_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status |-> o_x_center == POS_ONE && o_y_center == POS_ONE)
        else $error("singular result without centre (1,1)");

    // Every accepted item produces its result after the fixed latency.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |-> ##TOTAL_LAT o_done)
        else $error("accepted item lost");

    // No result appears without an item accepted at that distance.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, TOTAL_LAT))
        else $error("result without an accepted item");

endmodule

bind subpixel_center_3x3 scv_checker u_scv_checker (.*);

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for subpixel_center_3x3: directed patches, then random ones.
// Depends on scv_pkg and the subpixel_center_3x3 RTL; needs no other file.
module tb_top;
    import scv_pkg::*;

    localparam longint ONE_POS = 4096;

    typedef logic signed [PIX_W-1:0] patch_t [9];

    typedef struct {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic                    st;
    } center_t;

    // One row of the directed table. The expected centre is typed in only
    // where it is obvious; other rows go through the predictor alone.
    typedef struct {
        patch_t  pix;
        bit      typed;
        center_t want;
    } dir_row_t;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_start;
    logic                    o_busy;
    logic signed [PIX_W-1:0] pix [9];
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [GAIN_W-1:0]       i_cfg_data;
    logic                    o_done;
    logic signed [POS_W-1:0] o_x_center;
    logic signed [POS_W-1:0] o_y_center;
    logic                    o_status;

    subpixel_center_3x3 u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_pix_r0_c0 (pix[0]),
        .i_pix_r0_c1 (pix[1]),
        .i_pix_r0_c2 (pix[2]),
        .i_pix_r1_c0 (pix[3]),
        .i_pix_r1_c1 (pix[4]),
        .i_pix_r1_c2 (pix[5]),
        .i_pix_r2_c0 (pix[6]),
        .i_pix_r2_c1 (pix[7]),
        .i_pix_r2_c2 (pix[8]),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_done      (o_done),
        .o_x_center  (o_x_center),
        .o_y_center  (o_y_center),
        .o_status    (o_status)
    );

    // Testbench copy of the gain register and the queue of pending centers.
    logic [GAIN_W-1:0] gain_model;
    center_t           pending_centers [$];
    int                fail_count;
    int                items_sent;
    int                centers_seen;
    int                singular_seen;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit: far above the slowest legal run.
    initial begin
        #5ms;
        $display("** subpixel_center_3x3: FAILED **");
        $finish;
    end

    function automatic longint sat_q412(input longint v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    function automatic longint magnitude(input longint v);
        return v < 0 ? -v : v;
    endfunction

    // One-dimensional three-point peak: parabola vertex plus the gain-scaled
    // correction term; falls back to the brightest pixel when the curvature
    // is not positive or the correction denominator vanishes.
    function automatic longint peak_pos(input longint f0, input longint f1,
                                        input longint f2, input logic [GAIN_W-1:0] g);
        longint       curv, diff, a_term, e_term, t1, t2;
        logic [127:0] num, den, quot;
        bit           neg;
        curv = 2 * f1 - f0 - f2;
        diff = f2 - f0;
        if (curv > 0) begin
            a_term = 8 * curv * f1 + diff * diff;
            if (a_term != 0) begin
                t1 = (diff * (ONE_POS / 2)) / curv;
                e_term = (curv - diff) * (curv + diff);
                num = 128'(magnitude(e_term)) * 128'(magnitude(diff)) * 128'(g);
                // Gain is Q2.14 and centers carry 12 fraction bits: scale by 4.
                den = 128'(magnitude(a_term)) * 128'(curv) * 128'd4;
                quot = num / den;
                if (quot > (128'd1 << 40)) begin
                    quot = 128'd1 << 40;
                end
                t2 = longint'(quot[63:0]);
                neg = (diff < 0) ^ (e_term < 0) ^ (a_term < 0);
                if (neg) begin
                    t2 = -t2;
                end
                return sat_q412(ONE_POS + t1 + t2);
            end
        end
        if (f0 > f1 && f0 > f2) begin
            return 0;
        end
        if (f2 > f1 && f2 > f0) begin
            return 2 * ONE_POS;
        end
        return ONE_POS;
    endfunction

    // Full patch: six lane estimates, then the intersection of the row line
    // and the column line.
    function automatic center_t predict_center(input patch_t p, input logic [GAIN_W-1:0] g);
        longint  xm [3];
        longint  ym [3];
        longint  mx, my, bx, by, den, num, xc, yc;
        center_t r;
        for (int i = 0; i < 3; i++) begin
            xm[i] = peak_pos(p[3*i], p[3*i+1], p[3*i+2], g);
            ym[i] = peak_pos(p[i], p[i+3], p[i+6], g);
        end
        mx = xm[2] - xm[0];
        my = ym[2] - ym[0];
        bx = xm[0] + xm[1] + xm[2];
        by = ym[0] + ym[1] + ym[2];
        den = 12 * ONE_POS * ONE_POS + 3 * mx * my;
        if (den == 0) begin
            r.x = POS_ONE;
            r.y = POS_ONE;
            r.st = 1'b1;
        end else begin
            num = ONE_POS * (mx * (2 * by - 3 * my - 6 * ONE_POS) + 4 * ONE_POS * bx);
            xc = sat_q412(num / den);
            yc = sat_q412((3 * (xc - ONE_POS) * my + 2 * ONE_POS * by) / (6 * ONE_POS));
            r.x = POS_W'(xc);
            r.y = POS_W'(yc);
            r.st = 1'b0;
        end
        return r;
    endfunction

    // Monitor. Everything is sampled at the edge, before the block's own
    // updates land, so accepted items and strobed results are seen exactly once.
    always @(posedge i_clk) begin
        patch_t  cur;
        center_t want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                gain_model <= i_cfg_data;
            end
            if (i_start && !o_busy) begin
                for (int i = 0; i < 9; i++) begin
                    cur[i] = pix[i];
                end
                pending_centers.push_back(predict_center(cur, gain_model));
                items_sent <= items_sent + 1;
            end
            if (o_done) begin
                centers_seen <= centers_seen + 1;
                if (o_status) begin
                    singular_seen <= singular_seen + 1;
                end
                if (pending_centers.size() == 0) begin
                    $error("result strobe with no item pending");
                    fail_count++;
                end else begin
                    want = pending_centers.pop_front();
                    if (o_x_center !== want.x) begin
                        $error("x_center: expected %0d, got %0d", want.x, o_x_center);
                        fail_count++;
                    end
                    if (o_y_center !== want.y) begin
                        $error("y_center: expected %0d, got %0d", want.y, o_y_center);
                        fail_count++;
                    end
                    if (o_status !== want.st) begin
                        $error("status: expected %0d, got %0d", want.st, o_status);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Sender idling: bursts of random length, mostly followed by a random gap. A burst
    // length of 200 means a long stretch with no gaps at all.
    int burst_left;

    task automatic send_patch(input patch_t p);
        i_start <= 1'b1;
        for (int i = 0; i < 9; i++) begin
            pix[i] <= p[i];
        end
        do begin
            @(posedge i_clk);
        end while (o_busy);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 16);
            if ($urandom_range(0, 2) != 0) begin
                i_start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    endtask

    // The gain may only change with nothing in flight, so drain first and then
    // let the pipeline settle.
    task automatic write_gain(input logic [GAIN_W-1:0] g);
        i_start <= 1'b0;
        while (pending_centers.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TOTAL_LAT + 5) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= g;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random patch in one of several shapes: a bright peak with a random
    // offset (the main case), full-range noise, small noise, or a dip.
    function automatic patch_t random_patch();
        patch_t p;
        int     shape, peak, spread, base;
        shape = $urandom_range(0, 9);
        base = $urandom_range(0, 2000) - 1000;
        peak = $urandom_range(100, 30000);
        spread = $urandom_range(1, peak);
        for (int i = 0; i < 9; i++) begin
            if (shape < 5) begin
                p[i] = PIX_W'(base + int'($urandom_range(0, spread)));
            end else if (shape < 7) begin
                p[i] = PIX_W'($urandom);
            end else if (shape < 9) begin
                p[i] = PIX_W'(int'($urandom_range(0, 64)) - 32);
            end else begin
                p[i] = PIX_W'(base + int'($urandom_range(0, 200)));
            end
        end
        if (shape < 5) begin
            p[4] = PIX_W'(base + peak + int'($urandom_range(0, 500)));
        end else if (shape == 9) begin
            p[4] = PIX_W'(base - int'($urandom_range(0, 20000)));
        end
        return p;
    endfunction

    dir_row_t dir_table [$];

    function automatic dir_row_t mk_row(input int v [9], input bit typed,
                                        input int wx, input int wy);
        dir_row_t r;
        for (int i = 0; i < 9; i++) begin
            r.pix[i] = PIX_W'(v[i]);
        end
        r.typed = typed;
        r.want.x = POS_W'(wx);
        r.want.y = POS_W'(wy);
        r.want.st = 1'b0;
        return r;
    endfunction

    initial begin
        logic [GAIN_W-1:0] phase_gain [4];
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        for (int i = 0; i < 9; i++) begin
            pix[i] = '0;
        end
        gain_model = GAIN_RESET;
        fail_count = 0;
        items_sent = 0;
        centers_seen = 0;
        singular_seen = 0;
        burst_left = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Flat patches of any level, and a symmetric peak, sit exactly at 1,1.
        dir_table.push_back(mk_row('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, 4096, 4096));
        dir_table.push_back(mk_row('{32767, 32767, 32767, 32767, 32767, 32767,
                                     32767, 32767, 32767}, 1, 4096, 4096));
        dir_table.push_back(mk_row('{-32768, -32768, -32768, -32768, -32768, -32768,
                                     -32768, -32768, -32768}, 1, 4096, 4096));
        dir_table.push_back(mk_row('{0, 0, 0, 0, 100, 0, 0, 0, 0}, 1, 4096, 4096));
        // Negative curvature in every row with the left column brightest.
        dir_table.push_back(mk_row('{10, 0, 0, 10, 0, 0, 10, 0, 0}, 1, 0, 4096));
        // Extreme checkerboards, a single extreme corner, and negative peaks.
        dir_table.push_back(mk_row('{32767, -32768, 32767, -32768, 32767, -32768,
                                     32767, -32768, 32767}, 0, 0, 0));
        dir_table.push_back(mk_row('{-32768, 32767, -32768, 32767, -32768, 32767,
                                     -32768, 32767, -32768}, 0, 0, 0));
        dir_table.push_back(mk_row('{-32768, -32768, -32768, -32768, 32767, -32768,
                                     -32768, -32768, -32768}, 0, 0, 0));
        dir_table.push_back(mk_row('{0, 0, 0, 0, 0, 0, 0, 0, 32767}, 0, 0, 0));
        dir_table.push_back(mk_row('{-5, -3, -9, -2, -1, -4, -8, -6, -7}, 0, 0, 0));
        // Off-center peaks pull the estimate toward one side; a small centred peak ends the group.
        dir_table.push_back(mk_row('{0, 10, 5, 10, 40, 30, 5, 30, 20}, 0, 0, 0));
        dir_table.push_back(mk_row('{100, 200, 10, 300, 1000, 20, 50, 100, 0}, 0, 0, 0));
        dir_table.push_back(mk_row('{0, 1, 0, 1, 2, 1, 0, 1, 0}, 0, 0, 0));
        // Ties between the brightest pixels take the middle; a tilted ramp follows.
        dir_table.push_back(mk_row('{9, 0, 9, 0, 0, 0, 9, 0, 9}, 0, 0, 0));
        dir_table.push_back(mk_row('{-100, -200, -300, 0, 0, 0, 300, 200, 100}, 0, 0, 0));

        foreach (dir_table[k]) begin
            send_patch(dir_table[k].pix);
            if (dir_table[k].typed) begin
                // The predictor and the typed value must agree up front.
                center_t p;
                p = predict_center(dir_table[k].pix, gain_model);
                if (p.x != dir_table[k].want.x || p.y != dir_table[k].want.y ||
                    p.st != dir_table[k].want.st) begin
                    $error("directed row %0d: typed center %0d,%0d differs from %0d,%0d",
                           k, dir_table[k].want.x, dir_table[k].want.y, p.x, p.y);
                    fail_count++;
                end
            end
        end

        // Random phases under the extremes of the gain, the reset value and a random gain.
        phase_gain[0] = '0;
        phase_gain[1] = '1;
        phase_gain[2] = GAIN_RESET;
        phase_gain[3] = GAIN_W'($urandom);
        for (int ph = 0; ph < 4; ph++) begin
            write_gain(phase_gain[ph]);
            repeat (300) begin
                send_patch(random_patch());
            end
        end
        i_start <= 1'b0;

        while (pending_centers.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TOTAL_LAT + 10) @(posedge i_clk);
        if (pending_centers.size() != 0) begin
            $error("%0d centers never arrived", pending_centers.size());
            fail_count++;
        end

        $display("Sent %0d patches under 4 gain settings; checked %0d centers (%0d singular).",
                 items_sent, centers_seen, singular_seen);
        if (fail_count == 0) begin
            $display("** subpixel_center_3x3: PASSED **");
        end else begin
            $display("** subpixel_center_3x3: FAILED **");
        end
        $finish;
    end

endmodule
